// ----- rtl/lru_key_value_cache_defines.svh -----
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvc assertion failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc assertion failed");

`endif

// ----- rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

   localparam int KEY_W            = 32;
   localparam int VAL_W            = 31;
   localparam int CFG_W            = 5;
   localparam int CAPACITY_DEFAULT = 16;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [VAL_W-1:0] val_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } kv_cmd_type;

   typedef struct packed {
      logic    match;
      val_type value;
   } kv_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/lkvc_kv_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lkvc_kv_store #(
   parameter int  CAPACITY = lkvc_pkg::CAPACITY_DEFAULT,
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire                  clock,
   input  lkvc_pkg::kv_cmd_type cmd,
   input  wire [SLOT_W-1:0]     addr,
   input  lkvc_pkg::key_type    wr_key,
   input  lkvc_pkg::val_type    wr_value,
   input  lkvc_pkg::key_type    cmp_key,
   output lkvc_pkg::kv_rsp_type rsp
);
   import lkvc_pkg::*;

   localparam int ROW_W = KEY_W + VAL_W;

   logic [ROW_W-1:0] kv_mem [CAPACITY];
   logic [ROW_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         kv_mem[addr] <= {wr_key, wr_value};
      end
      if (cmd.rd_en) begin
         rd_ff <= kv_mem[addr];
      end
   end

   // shared key comparator
   assign rsp.match = (rd_ff[ROW_W-1 -: KEY_W] == cmp_key);
   assign rsp.value = rd_ff[VAL_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_defines.svh"

// Channel   Handshake            Payload
// request   start / busy         req_type, req_key, req_value
// response  rsp_valid (strobe)   rsp_found, rsp_read_value
// config    csr_valid/csr_ready  csr_data
//
// A request reads one key per slot through the single table read port and comparator,
// then passes through the pipeline tail state and the update state.
// The response strobes in the update state; a new request is taken then too.
// Synchronous active-high reset clears valid marks, ranks and occupancy; capacity returns to 16.
// Responses cannot be stalled; csr writes are taken only while idle.

module lru_key_value_cache #(
   parameter int  CAPACITY = lkvc_pkg::CAPACITY_DEFAULT,
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int OCC_W    = $clog2(CAPACITY + 1)
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire                        req_type,
   input  lkvc_pkg::key_type          req_key,
   input  lkvc_pkg::val_type          req_value,
   output logic                       rsp_valid,
   output logic                       rsp_found,
   output lkvc_pkg::val_type          rsp_read_value,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [lkvc_pkg::CFG_W-1:0]  csr_data
);
   import lkvc_pkg::*;

   localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

   state_type state_ff, state_in;

   logic              req_type_ff, req_type_in;
   key_type           key_ff, key_in;
   val_type           value_ff, value_in;
   logic [SLOT_W-1:0] issue_idx_ff, issue_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic [SLOT_W-1:0] hit_rank_ff, hit_rank_in;
   val_type           hit_val_ff, hit_val_in;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic              lru_found_ff, lru_found_in;
   logic [SLOT_W-1:0] lru_slot_ff, lru_slot_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0] rank_ff [CAPACITY];
   logic [SLOT_W-1:0] rank_in [CAPACITY];
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [CFG_W-1:0]  cap_ff, cap_in;

   logic              accept;
   logic              is_put;
   logic              full;
   logic              do_update;
   logic              do_insert;
   logic [CMP_W-1:0]  cap_ext;
   logic [CMP_W-1:0]  eff_cap;
   logic [SLOT_W-1:0] occ_m1;
   logic [SLOT_W-1:0] upd_rank;
   logic [SLOT_W-1:0] target;
   logic [SLOT_W-1:0] mem_addr;
   kv_cmd_type        kv_cmd;
   kv_rsp_type        kv_rsp;

   lkvc_kv_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock    (clock),
      .cmd      (kv_cmd),
      .addr     (mem_addr),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .cmp_key  (key_ff),
      .rsp      (kv_rsp)
   );

   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(CAPACITY)) begin
         eff_cap = CMP_W'(CAPACITY);
      end else begin
         eff_cap = cap_ext;
      end
      full   = (CMP_W'(occ_ff) >= eff_cap);
      occ_m1 = SLOT_W'(occ_ff - OCC_W'(1));
      is_put = (req_type_ff == REQ_PUT);
      if (hit_ff) begin
         upd_rank = hit_rank_ff;
         target   = hit_slot_ff;
      end else if (full) begin
         upd_rank = occ_m1;
         target   = lru_slot_ff;
      end else begin
         upd_rank = SLOT_W'(occ_ff);
         target   = free_slot_ff;
      end
      do_update = (state_ff == ST_UPDATE) && (hit_ff || is_put);
      do_insert = (state_ff == ST_UPDATE) && is_put && !hit_ff && !full;
   end

   // next state
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = start ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            state_in = (issue_idx_ff == SLOT_W'(CAPACITY - 1)) ? ST_TAIL : ST_SCAN;
         end
         ST_TAIL: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = start ? ST_SCAN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy           = (state_ff == ST_SCAN) || (state_ff == ST_TAIL);
      rsp_valid      = (state_ff == ST_UPDATE);
      csr_ready      = (state_ff == ST_IDLE);
      rsp_found      = hit_ff;
      rsp_read_value = (req_type_ff == REQ_GET && hit_ff) ? hit_val_ff : '0;
      kv_cmd.rd_en   = (state_ff == ST_SCAN);
      kv_cmd.wr_en   = (state_ff == ST_UPDATE) && is_put;
      mem_addr       = (state_ff == ST_SCAN) ? issue_idx_ff : target;
   end

   assign accept = start && !busy;

   // datapath next values
   always_comb begin
      req_type_in   = req_type_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      issue_idx_in  = issue_idx_ff;
      cmp_vld_in    = (state_ff == ST_SCAN);
      cmp_idx_in    = issue_idx_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      hit_val_in    = hit_val_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      lru_found_in  = lru_found_ff;
      lru_slot_in   = lru_slot_ff;
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      occ_in        = occ_ff;
      cap_in        = cap_ff;

      if (state_ff == ST_SCAN) begin
         issue_idx_in = issue_idx_ff + SLOT_W'(1);
      end

      if (cmp_vld_ff) begin
         if (valid_ff[cmp_idx_ff] && kv_rsp.match && !hit_ff) begin
            hit_in      = 1'b1;
            hit_slot_in = cmp_idx_ff;
            hit_rank_in = rank_ff[cmp_idx_ff];
            hit_val_in  = kv_rsp.value;
         end
         if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = cmp_idx_ff;
         end
         if (valid_ff[cmp_idx_ff] && rank_ff[cmp_idx_ff] == occ_m1) begin
            lru_found_in = 1'b1;
            lru_slot_in  = cmp_idx_ff;
         end
      end

      // touch: entries more recent than the target age by one
      if (do_update) begin
         for (int j = 0; j < CAPACITY; j++) begin
            if (valid_ff[j] && rank_ff[j] < upd_rank) begin
               rank_in[j] = rank_ff[j] + SLOT_W'(1);
            end
         end
         rank_in[target]  = '0;
         valid_in[target] = 1'b1;
      end
      if (do_insert) begin
         occ_in = occ_ff + OCC_W'(1);
      end

      if (accept) begin
         req_type_in   = req_type;
         key_in        = req_key;
         value_in      = req_value;
         issue_idx_in  = '0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
         lru_found_in  = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         lru_found_ff  <= 1'b0;
         valid_ff      <= '0;
         rank_ff       <= '{default: '0};
         occ_ff        <= '0;
         cap_ff        <= CFG_RESET;
         issue_idx_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         lru_found_ff  <= lru_found_in;
         valid_ff      <= valid_in;
         rank_ff       <= rank_in;
         occ_ff        <= occ_in;
         cap_ff        <= cap_in;
         issue_idx_ff  <= issue_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff  <= req_type_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_slot_ff  <= hit_slot_in;
      hit_rank_ff  <= hit_rank_in;
      hit_val_ff   <= hit_val_in;
      free_slot_ff <= free_slot_in;
      lru_slot_ff  <= lru_slot_in;
   end

   `LKVC_ASSERT_NOW(a_occ_matches_valid, clock, reset, 1'b1, $countones(valid_ff) == int'(occ_ff))
   `LKVC_ASSERT_NEXT(a_tail_then_resp, clock, reset, state_ff == ST_TAIL, rsp_valid)
   `LKVC_ASSERT_NOW(a_insert_has_free, clock, reset, do_insert, free_found_ff)
   `LKVC_ASSERT_NOW(a_evict_has_lru, clock, reset, rsp_valid && is_put && !hit_ff && full, lru_found_ff)

endmodule

`default_nettype wire
